// ===== rtl/ttv_pkg.sv =====
package ttv_pkg;

    localparam int unsigned PosW = 32;
    localparam int unsigned TexW = 16;
    localparam int unsigned SlotW = 10;
    localparam int unsigned EdgeW = 33;
    localparam int unsigned DeltaW = 17;
    localparam int unsigned DetW = 35;
    localparam int unsigned NumW = 51;
    localparam int unsigned DivW = 63;
    localparam int unsigned QCntW = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TANGENT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_LATCH,
        ST_DET0,
        ST_DET1,
        ST_NUM0,
        ST_NUM1,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             op;
        logic [SlotW-1:0] vertex_slot;
        logic [PosW-1:0]  pos_x;
        logic [PosW-1:0]  pos_y;
        logic [PosW-1:0]  pos_z;
        logic [TexW-1:0]  tex_u;
        logic [TexW-1:0]  tex_v;
        logic [SlotW-1:0] corner_a;
        logic [SlotW-1:0] corner_b;
        logic [SlotW-1:0] corner_c;
    } t_in_item;

    typedef struct packed {
        logic [PosW-1:0] tangent_x;
        logic [PosW-1:0] tangent_y;
        logic [PosW-1:0] tangent_z;
        logic            degenerate;
        logic            clipped;
    } t_out_item;

    // divider control between sequencer and divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

// ===== rtl/ttv_if.sv =====
interface ttv_in_if;
    import ttv_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ttv_out_if;
    import ttv_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ttv_store.sv =====
module ttv_store #(
    parameter int unsigned Depth = 1024,
    parameter int unsigned AddrW = 10
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AddrW-1:0]        i_waddr,
    input  logic [4*ttv_pkg::PosW-1:0] i_wdata,
    input  logic [AddrW-1:0]        i_raddr,
    output logic [4*ttv_pkg::PosW-1:0] o_rdata
);
    import ttv_pkg::*;

    logic [4*PosW-1:0] r_mem [Depth];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/ttv_div.sv =====
module ttv_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [ttv_pkg::DivW-1:0] i_num,
    input  logic signed [ttv_pkg::DetW-1:0] i_den,
    output ttv_pkg::t_div_ctl            o_ctl,
    output logic signed [ttv_pkg::DivW-1:0] o_quo
);
    import ttv_pkg::*;

    logic [DivW-1:0]  r_rem_q;
    logic [DetW:0]    r_rem;
    logic [DetW-1:0]  r_den;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [QCntW-1:0] r_cnt;
    logic [DetW:0]    w_shift;
    logic [DetW:0]    w_diff;

    // restoring radix-2 step on magnitudes
    assign w_shift = {r_rem[DetW-1:0], r_rem_q[DivW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= QCntW'(DivW - 1);
                r_rem   <= '0;
                r_rem_q <= i_num[DivW-1] ? DivW'(-i_num) : DivW'(i_num);
                r_den   <= i_den[DetW-1] ? DetW'(-i_den) : DetW'(i_den);
                r_neg   <= i_num[DivW-1] ^ i_den[DetW-1];
            end else if (r_busy) begin
                if (!w_diff[DetW]) begin
                    r_rem   <= w_diff;
                    r_rem_q <= {r_rem_q[DivW-2:0], 1'b1};
                end else begin
                    r_rem   <= w_shift;
                    r_rem_q <= {r_rem_q[DivW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - QCntW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quo       = r_neg ? DivW'(-r_rem_q) : DivW'(r_rem_q);
endmodule

// ===== rtl/triangle_tangent_vector.sv =====
// channel  dir  payload                                   transfer when
// i_in     in   op, slot, pos xyz, tex uv, corners a b c  valid & ready
// o_out    out  tangent xyz, degenerate, clipped          valid & ready
// A tangent reads the three corners from the store (ST_RD_A to ST_LATCH), forms
// the determinant (ST_DET0, ST_DET1), then per component multiplies (ST_NUM0,
// ST_NUM1), divides (ST_DIV) and saturates (ST_NEXT), then offers the result.
// Most of the run time goes to the radix-2 divider (one quotient bit a cycle, 63 bits).
// A zero determinant skips the divides: ST_NUM0 goes straight to ST_OUT.
// Reset (i_rst_n low, synchronous) clears control only; the store is not cleared.
// Input is held off while a tangent runs and while its result waits.
module triangle_tangent_vector #(
    parameter int unsigned VERTEX_COUNT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttv_in_if.sink    i_in,
    ttv_out_if.source o_out
);
    import ttv_pkg::*;

    localparam int unsigned AddrW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    t_state r_state, n_state;

    logic [4*PosW-1:0] w_rdata;
    logic [AddrW-1:0]  w_raddr;
    logic              w_we;
    logic [SlotW-1:0]  r_ca, r_cb, r_cc;
    logic [2:0]        r_oob;
    logic signed [PosW-1:0] r_pa [3];
    logic signed [PosW-1:0] r_pb [3];
    logic signed [PosW-1:0] r_pc [3];
    logic signed [TexW-1:0] r_ua, r_va, r_ub, r_vb, r_uc, r_vc;
    logic signed [DeltaW-1:0] w_u0, w_u1, w_v0, w_v1;
    logic signed [DetW-1:0] r_det;
    logic signed [NumW-1:0] r_prod;
    logic signed [NumW-1:0] r_num;
    logic [1:0]   r_k;
    logic signed [PosW-1:0] r_t [3];
    logic         r_clip, r_degen;
    t_div_ctl     w_dctl;
    logic signed [DivW-1:0] w_quo;
    logic         w_dstart;

    // shared multiplier operands
    logic signed [EdgeW-1:0] w_ma;
    logic signed [DeltaW-1:0] w_mb;
    logic signed [EdgeW+DeltaW-1:0] w_mp;
    logic signed [EdgeW-1:0] w_e0, w_e1;

    assign w_we = i_in.valid && i_in.ready && (i_in.data.op == OP_WRITE)
                  && (32'(i_in.data.vertex_slot) < VERTEX_COUNT);

    ttv_store #(.Depth(VERTEX_COUNT), .AddrW(AddrW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AddrW'(i_in.data.vertex_slot)),
        .i_wdata ({i_in.data.tex_v, i_in.data.tex_u, i_in.data.pos_z,
                   i_in.data.pos_y, i_in.data.pos_x}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // read address follows the fetch sequence; data lands in the next cycle
    always_comb begin
        case (r_state)
            ST_RD_B: w_raddr = AddrW'(r_cb);
            ST_RD_C: w_raddr = AddrW'(r_cc);
            default: w_raddr = AddrW'(r_ca);
        endcase
    end

    assign w_u0 = DeltaW'(r_ub) - DeltaW'(r_ua);
    assign w_u1 = DeltaW'(r_uc) - DeltaW'(r_ua);
    assign w_v0 = DeltaW'(r_vb) - DeltaW'(r_va);
    assign w_v1 = DeltaW'(r_vc) - DeltaW'(r_va);
    assign w_e0 = EdgeW'(r_pb[r_k]) - EdgeW'(r_pa[r_k]);
    assign w_e1 = EdgeW'(r_pc[r_k]) - EdgeW'(r_pa[r_k]);

    always_comb begin
        case (r_state)
            ST_DET0: begin w_ma = EdgeW'(w_u0); w_mb = w_v1; end
            ST_DET1: begin w_ma = EdgeW'(w_u1); w_mb = w_v0; end
            ST_NUM0: begin w_ma = w_e0; w_mb = w_v1; end
            default: begin w_ma = w_e1; w_mb = w_v0; end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in.valid && i_in.data.op == OP_TANGENT) n_state = ST_RD_A;
            ST_RD_A:  n_state = ST_RD_B;
            ST_RD_B:  n_state = ST_RD_C;
            ST_RD_C:  n_state = ST_LATCH;
            ST_LATCH: n_state = ST_DET0;
            ST_DET0:  n_state = ST_DET1;
            ST_DET1:  n_state = ST_NUM0;
            ST_NUM0:  n_state = (r_det == '0) ? ST_OUT : ST_NUM1;
            ST_NUM1:  n_state = ST_DIV;
            ST_DIV:   if (w_dctl.done) n_state = ST_NEXT;
            ST_NEXT:  n_state = (r_k == 2'd2) ? ST_OUT : ST_NUM0;
            ST_OUT:   if (o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
        o_out.valid = (r_state == ST_OUT);
        w_dstart = (r_state == ST_NUM1);
    end

    assign o_out.data.tangent_x  = r_t[0];
    assign o_out.data.tangent_y  = r_t[1];
    assign o_out.data.tangent_z  = r_t[2];
    assign o_out.data.degenerate = r_degen;
    assign o_out.data.clipped    = r_clip;

    ttv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   ({r_num - NumW'(w_mp), 12'd0}),
        .i_den   (r_det),
        .o_ctl   (w_dctl),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ca <= i_in.data.corner_a;
                r_cb <= i_in.data.corner_b;
                r_cc <= i_in.data.corner_c;
                r_oob <= {32'(i_in.data.corner_c) >= VERTEX_COUNT,
                          32'(i_in.data.corner_b) >= VERTEX_COUNT,
                          32'(i_in.data.corner_a) >= VERTEX_COUNT};
                r_k <= 2'd0;
                r_clip <= 1'b0;
            end
            ST_RD_B, ST_RD_C, ST_LATCH: begin
                logic [4*PosW-1:0] v;
                v = '0;
                if (r_state == ST_RD_B && !r_oob[0]) v = w_rdata;
                if (r_state == ST_RD_C && !r_oob[1]) v = w_rdata;
                if (r_state == ST_LATCH && !r_oob[2]) v = w_rdata;
                if (r_state == ST_RD_B) begin
                    r_pa[0] <= v[31:0]; r_pa[1] <= v[63:32]; r_pa[2] <= v[95:64];
                    r_ua <= v[111:96]; r_va <= v[127:112];
                end else if (r_state == ST_RD_C) begin
                    r_pb[0] <= v[31:0]; r_pb[1] <= v[63:32]; r_pb[2] <= v[95:64];
                    r_ub <= v[111:96]; r_vb <= v[127:112];
                end else begin
                    r_pc[0] <= v[31:0]; r_pc[1] <= v[63:32]; r_pc[2] <= v[95:64];
                    r_uc <= v[111:96]; r_vc <= v[127:112];
                end
            end
            ST_DET0: r_prod <= NumW'(w_mp);
            ST_DET1: r_det <= DetW'(r_prod) - DetW'(w_mp);
            ST_NUM0: begin
                r_num <= NumW'(w_mp);
                r_degen <= (r_det == '0);
                if (r_det == '0) begin
                    r_t[0] <= '0; r_t[1] <= '0; r_t[2] <= '0;
                end
            end
            ST_NEXT: begin
                if (w_quo > DivW'(64'sh7FFFFFFF)) begin
                    r_t[r_k] <= 32'h7FFF_FFFF; r_clip <= 1'b1;
                end else if (w_quo < -DivW'(64'sh80000000)) begin
                    r_t[r_k] <= 32'h8000_0000; r_clip <= 1'b1;
                end else begin
                    r_t[r_k] <= w_quo[PosW-1:0];
                end
                r_k <= r_k + 2'd1;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/ttv_checker.sv =====
module ttv_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_degenerate,
    input logic i_clipped,
    input logic [31:0] i_tx
);
    // never both ready for input and offering a result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready while result pending");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx))
        else $error("result dropped");
    // degenerate results have a zero x tangent and are unclipped
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_tx == '0 && !i_clipped)
        else $error("bad degenerate result");
endmodule

bind triangle_tangent_vector ttv_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_degenerate(o_out.data.degenerate), .i_clipped(o_out.data.clipped),
    .i_tx(o_out.data.tangent_x)
);
